// ----- sv/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg: shared types for the address region table
// payload structs, lookup token, slot write, command and register codes, state encoding
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int unsigned NumRegions = 64;
  localparam int unsigned SlotW      = 6;
  localparam int unsigned AddrW      = 64;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_GAP    = 2'd2,
    CMD_RANGE  = 2'd3
  } arc_cmd_e;

  typedef enum logic [1:0] {
    REG_PAGE_BITS = 2'd0,
    REG_USER_BASE = 2'd1,
    REG_USER_END  = 2'd2
  } arc_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FIT,
    ST_RANGE,
    ST_WALK,
    ST_OUT
  } arc_state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [SlotW-1:0] slot;
    logic             slot_valid;
    logic [AddrW-1:0] new_start;
    logic [AddrW-1:0] new_end;
    logic [AddrW-1:0] address;
    logic [AddrW-1:0] size;
  } arc_in_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] hit_slot;
    logic [AddrW-1:0] hit_start;
    logic [AddrW-1:0] hit_end;
    logic [AddrW-1:0] result_address;
  } arc_out_t;

  // token walking the cell chain
  typedef struct packed {
    logic             vld;
    logic             gap;
    logic             done;
    logic             found;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] hit_start;
    logic [AddrW-1:0] hit_end;
    logic [AddrW-1:0] cursor;
    logic [AddrW-1:0] size;
  } arc_tok_t;

  // slot write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] slot;
    logic             valid;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] stop;
  } arc_wr_t;

endpackage

// ----- sv/arc_cell.sv -----
// ----------------------------------------------------------------------------
// arc_cell: one region slot of the table
// holds start, end and valid, updates the passing token for one step
// ----------------------------------------------------------------------------
module arc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [arc_pkg::SlotW-1:0]    idx_i,
  input  arc_pkg::arc_wr_t             wr_i,
  input  logic [arc_pkg::AddrW-1:0]    user_end_i,
  input  arc_pkg::arc_tok_t            tok_i,
  output arc_pkg::arc_tok_t            tok_o
);

  logic                      valid_q;
  logic [arc_pkg::AddrW-1:0] start_q;
  logic [arc_pkg::AddrW-1:0] end_q;
  arc_pkg::arc_tok_t         tok_d;
  arc_pkg::arc_tok_t         tok_q;
  logic                      wr_hit;

  assign wr_hit = wr_i.en && (wr_i.slot == idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_hit) begin
      valid_q <= wr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      start_q <= wr_i.start;
      end_q   <= wr_i.stop;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done && valid_q) begin
      if (!tok_i.gap) begin
        if (tok_i.cursor >= start_q && tok_i.cursor < end_q) begin
          tok_d.done      = 1'b1;
          tok_d.found     = 1'b1;
          tok_d.slot      = idx_i;
          tok_d.hit_start = start_q;
          tok_d.hit_end   = end_q;
        end
      end else if (end_q > tok_i.cursor) begin
        if (start_q >= tok_i.cursor && tok_i.size <= start_q - tok_i.cursor) begin
          // gap before this region is large enough
          tok_d.done  = 1'b1;
          tok_d.found = 1'b1;
        end else begin
          tok_d.cursor = end_q;
          if (!(end_q < user_end_i && tok_i.size <= user_end_i - end_q)) begin
            tok_d.done = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- sv/address_region_table_core.sv -----
// ----------------------------------------------------------------------------
// address_region_table_core: region table with lookup, gap search, range check
// 64 region cells in a chain, a token walks one cell per cycle
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid_i/in_ready_o/in_data_i) takes one command per
//   transfer; a new command is taken only once the previous result has been
//   handed off, so one item is in flight at a time
// - output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per command, held in an output register until transferred
// - a slot write and a range check go straight to the output register; a lookup
//   walks the 64-cell chain, a gap search rounds its hint (PREP, FIT), then walks it
// - a stalled receiver holds the result; the input stays not ready meanwhile
// - reset clears every valid bit at once (no clearing pass), restores
//   page_bits 12, user_base 4096, user_end 2^47
// - registers live at 0x0, 0x8, 0x10 on the APB-style port, 64-bit data;
//   write them only while the block is idle
// ----------------------------------------------------------------------------
module address_region_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  arc_pkg::arc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output arc_pkg::arc_out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = arc_pkg::AddrW;

  // configuration registers
  logic [4:0]    page_bits_q;
  logic [AW-1:0] user_base_q;
  logic [AW-1:0] user_end_q;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bits_q <= 5'd12;
      user_base_q <= 64'd4096;
      user_end_q  <= 64'd140737488355328;
    end else if (cfg_we) begin
      unique case (arc_pkg::arc_reg_e'(paddr[4:3]))
        arc_pkg::REG_PAGE_BITS: page_bits_q <= pwdata[4:0];
        arc_pkg::REG_USER_BASE: user_base_q <= pwdata;
        arc_pkg::REG_USER_END:  user_end_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (arc_pkg::arc_reg_e'(paddr[4:3]))
      arc_pkg::REG_PAGE_BITS: prdata = {59'd0, page_bits_q};
      arc_pkg::REG_USER_BASE: prdata = user_base_q;
      arc_pkg::REG_USER_END:  prdata = user_end_q;
      default:                prdata = '0;
    endcase
  end

  // control and datapath registers
  arc_pkg::arc_state_e state_q, state_d;
  arc_pkg::arc_in_t    req_q;
  arc_pkg::arc_out_t   res_q, res_d;
  logic [AW-1:0]       cur_q, cur_d;    // rounded gap cursor
  logic                over_q, over_d;  // rounding wrapped past 2^64
  logic                in_fire;
  logic [AW-1:0]       mask;
  logic [AW-1:0]       clamp;
  logic                fit_ok;
  logic [AW-1:0]       fit_cursor;
  logic                tail_fits;
  arc_pkg::arc_wr_t    wr;
  arc_pkg::arc_tok_t   tok [arc_pkg::NumRegions+1];

  assign mask    = ~({AW{1'b1}} << page_bits_q);
  assign in_fire = in_valid_i && in_ready_o;
  assign clamp   = (req_q.address < user_base_q) ? user_base_q : req_q.address;

  // window fit of the rounded hint
  assign fit_ok     = !over_q && cur_q < user_end_q && req_q.size <= user_end_q - cur_q;
  assign fit_cursor = fit_ok ? cur_q : user_base_q;

  // window fit of the cursor after the last cell
  assign tail_fits = tok[arc_pkg::NumRegions].cursor < user_end_q &&
                     tok[arc_pkg::NumRegions].size <= user_end_q - tok[arc_pkg::NumRegions].cursor;

  // slot write goes straight from the input transfer
  always_comb begin
    wr.en    = in_fire && (arc_pkg::arc_cmd_e'(in_data_i.command) == arc_pkg::CMD_WRITE);
    wr.slot  = in_data_i.slot;
    wr.valid = in_data_i.slot_valid;
    wr.start = in_data_i.new_start;
    wr.stop  = in_data_i.new_end;
  end

  // token entering the chain
  always_comb begin
    tok[0]           = '0;
    tok[0].hit_start = '0;
    if (state_q == arc_pkg::ST_IDLE && in_fire &&
        arc_pkg::arc_cmd_e'(in_data_i.command) == arc_pkg::CMD_LOOKUP) begin
      tok[0].vld    = 1'b1;
      tok[0].cursor = in_data_i.address;
    end else if (state_q == arc_pkg::ST_FIT) begin
      tok[0].vld    = 1'b1;
      tok[0].gap    = 1'b1;
      tok[0].cursor = fit_cursor;
      tok[0].size   = req_q.size;
    end
  end

  // chain of region cells
  for (genvar i = 0; i < arc_pkg::NumRegions; i++) begin : g_cell
    arc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (arc_pkg::SlotW'(i)),
      .wr_i       (wr),
      .user_end_i (user_end_q),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cur_d   = cur_q;
    over_d  = over_q;
    unique case (state_q)
      arc_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          unique case (arc_pkg::arc_cmd_e'(in_data_i.command))
            arc_pkg::CMD_WRITE: begin
              res_d.found = 1'b1;
              state_d     = arc_pkg::ST_OUT;
            end
            arc_pkg::CMD_LOOKUP: state_d = arc_pkg::ST_WALK;
            arc_pkg::CMD_GAP:    state_d = arc_pkg::ST_PREP;
            arc_pkg::CMD_RANGE:  state_d = arc_pkg::ST_RANGE;
            default:             state_d = arc_pkg::ST_OUT;
          endcase
        end
      end
      arc_pkg::ST_PREP: begin
        // clamp hint to base, round up to the page
        over_d  = clamp > ~mask;
        cur_d   = (clamp + mask) & ~mask;
        state_d = arc_pkg::ST_FIT;
      end
      arc_pkg::ST_FIT: begin
        state_d = arc_pkg::ST_WALK;
      end
      arc_pkg::ST_RANGE: begin
        res_d = '0;
        if (req_q.size != '0 && (req_q.size & mask) == '0 &&
            req_q.address >= user_base_q && (req_q.address & mask) == '0 &&
            req_q.address < user_end_q && req_q.size <= user_end_q - req_q.address) begin
          res_d.found          = 1'b1;
          res_d.result_address = req_q.address + req_q.size;
        end
        state_d = arc_pkg::ST_OUT;
      end
      arc_pkg::ST_WALK: begin
        if (tok[arc_pkg::NumRegions].vld) begin
          res_d = '0;
          if (!tok[arc_pkg::NumRegions].gap) begin
            res_d.found     = tok[arc_pkg::NumRegions].found;
            res_d.hit_slot  = tok[arc_pkg::NumRegions].slot;
            res_d.hit_start = tok[arc_pkg::NumRegions].hit_start;
            res_d.hit_end   = tok[arc_pkg::NumRegions].hit_end;
          end else if (tok[arc_pkg::NumRegions].found ||
                       (!tok[arc_pkg::NumRegions].done && tail_fits)) begin
            res_d.found          = 1'b1;
            res_d.result_address = tok[arc_pkg::NumRegions].cursor;
          end
          state_d = arc_pkg::ST_OUT;
        end
      end
      arc_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = arc_pkg::ST_IDLE;
        end
      end
      default: state_d = arc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    res_q  <= res_d;
    cur_q  <= cur_d;
    over_q <= over_d;
  end

  assign in_ready_o  = (state_q == arc_pkg::ST_IDLE);
  assign out_valid_o = (state_q == arc_pkg::ST_OUT);
  assign out_data_o  = res_q;

endmodule
